/* src/rlgr3_pkg.sv */
// Shared constants and helper functions for the RLGR3 coefficient decoder.
// No dependencies.
`default_nettype none
package rlgr3_pkg;

  localparam logic [6:0] PARAM_MAX  = 7'd80;
  localparam logic [6:0] PARAM_INIT = 7'd8;
  localparam logic [6:0] RUN_UP     = 7'd4;
  localparam logic [6:0] RUN_STEP   = 7'd6;
  localparam logic [6:0] RICE_DOWN  = 7'd2;

  typedef logic [15:0] coef_t;

  function automatic logic [4:0] bit_length(input logic [15:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) n = 5'(i + 1);
    end
    return n;
  endfunction

  function automatic coef_t from_mag_sign(input logic signed [17:0] d);
    logic signed [17:0] t;
    t = d + 18'sd1;
    if (d[0]) return coef_t'(18'sd0 - (t >>> 1));
    return coef_t'(d >>> 1);
  endfunction

  function automatic logic [6:0] sat_sub(input logic [6:0] v, input logic [6:0] s);
    return (v >= s) ? v - s : 7'd0;
  endfunction

  function automatic logic [6:0] sat_add(input logic [6:0] v, input logic [6:0] s);
    logic [7:0] t;
    t = {1'b0, v} + {1'b0, s};
    return (t > {1'b0, PARAM_MAX}) ? PARAM_MAX : t[6:0];
  endfunction

endpackage
`default_nettype wire

/* src/rlgr3_coefficient_decoder_core.sv */
// RLGR3 decoder top level: byte buffer, bit sequencer and coefficient store.
// A byte is taken on a handshake; a coefficient read passes the RAM read register and then
// the output register. A flagged byte starts a decode: a store clear, then the bit-serial
// decode, with bytes fetched from the stream RAM as the reservoir empties, then a running
// sum over the entries from DIFF_START upward when DIFF_START is below COEF_TOTAL.
// After reset the coefficient store is cleared before requests are taken.
`default_nettype none
module rlgr3_coefficient_decoder_core #(
  parameter int MAX_STREAM_BYTES = 8192,
  parameter int COEF_TOTAL       = 4096,
  parameter int DIFF_START       = 4032
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_mode,
  input  wire logic [7:0]         in_data_byte,
  input  wire logic               in_last_byte,
  input  wire logic [11:0]        in_coef_index,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_is_count,
  output logic signed [15:0]      out_coef_value,
  output logic [12:0]             out_coef_count
);

  localparam int SW = $clog2(MAX_STREAM_BYTES);
  localparam int LW = SW + 1;
  localparam int CW = $clog2(COEF_TOTAL);
  localparam logic [LW-1:0] MAX_LEN = LW'(MAX_STREAM_BYTES);
  localparam logic [12:0] TOTAL = 13'(COEF_TOTAL);
  localparam logic [CW-1:0] DS_ADDR = CW'(DIFF_START);
  localparam logic [CW-1:0] LAST_ADDR = CW'(COEF_TOTAL - 1);
  localparam bit DIFF_ON = (DIFF_START < COEF_TOTAL);

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_CLR       = 5'd1;
  localparam logic [4:0] S_RD_WAIT   = 5'd2;
  localparam logic [4:0] S_TOP       = 5'd3;
  localparam logic [4:0] S_FETCH     = 5'd4;
  localparam logic [4:0] S_RUN_BIT   = 5'd5;
  localparam logic [4:0] S_RUN_K     = 5'd6;
  localparam logic [4:0] S_RUN_SIGN  = 5'd7;
  localparam logic [4:0] S_RICE_ONES = 5'd8;
  localparam logic [4:0] S_RICE_LOW  = 5'd9;
  localparam logic [4:0] S_RUN_PUT   = 5'd10;
  localparam logic [4:0] S_GR_SETUP  = 5'd11;
  localparam logic [4:0] S_GR_V1     = 5'd12;
  localparam logic [4:0] S_GR_PUT1   = 5'd13;
  localparam logic [4:0] S_GR_PUT2   = 5'd14;
  localparam logic [4:0] S_FINISH    = 5'd15;
  localparam logic [4:0] S_DIFF_RD   = 5'd16;
  localparam logic [4:0] S_DIFF_WR   = 5'd17;
  localparam logic [4:0] S_DONE      = 5'd18;

  logic [4:0]    state_r, state_nxt, ret_r, ret_nxt;
  logic [LW-1:0] len_r, len_nxt, rp_r, rp_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic [3:0]    fill_r, fill_nxt;
  logic [6:0]    run_r, run_nxt, kr_r, kr_nxt, ones_r, ones_nxt;
  logic [12:0]   wp_r, wp_nxt;
  logic [15:0]   val_r, val_nxt, sum_r, sum_nxt, acc_r, acc_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  logic          sign_r, sign_nxt, rice_gr_r, rice_gr_nxt;
  logic          go_dec_r, go_dec_nxt, oob_r, oob_nxt;
  logic [CW-1:0] cidx_r, cidx_nxt;
  logic          out_valid_r, out_valid_nxt, out_is_count_r, out_is_count_nxt;
  logic [15:0]   out_value_r, out_value_nxt;
  logic [12:0]   out_count_r, out_count_nxt;

  logic          s_we;
  logic [7:0]    s_rdata;
  logic          c_we;
  logic [CW-1:0] c_waddr, c_raddr;
  rlgr3_pkg::coef_t c_wdata, c_rdata;

  logic          accept, need_fetch, stream_done, cur_bit;
  logic [2:0]    bit_idx;
  logic [12:0]   wp_run, wp_one, wp_two;
  logic [16:0]   mag;
  logic signed [17:0] d2;
  logic [15:0]   diff_sum;

  rlgr3_ram #(.WIDTH(8), .DEPTH(MAX_STREAM_BYTES)) u_stream_ram (
    .clk(clk), .we(s_we), .waddr(len_r[SW-1:0]), .wdata(in_data_byte),
    .raddr(rp_r[SW-1:0]), .rdata(s_rdata)
  );

  rlgr3_ram #(.WIDTH(16), .DEPTH(COEF_TOTAL)) u_coef_ram (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept = in_valid && in_ready;
  assign s_we = accept && !in_mode && (len_r < MAX_LEN);
  assign c_raddr = (state_r == S_DIFF_RD) ? cidx_r : in_coef_index[CW-1:0];

  assign stream_done = (fill_r == 4'd0) && (rp_r >= len_r);
  assign need_fetch = (fill_r == 4'd0) && (rp_r < len_r);
  assign bit_idx = 3'(fill_r - 4'd1);
  assign cur_bit = (fill_r != 4'd0) && byte_r[bit_idx];

  assign wp_run = wp_r + (13'd1 << run_r[6:3]);
  assign wp_one = wp_r + 13'd1;
  assign wp_two = wp_r + 13'd2;
  assign mag = {1'b0, val_r} + 17'd1;
  assign d2 = $signed({2'b00, sum_r}) - $signed({2'b00, val_r});
  assign diff_sum = (cidx_r == DS_ADDR) ? c_rdata : acc_r + c_rdata;

  assign out_valid = out_valid_r;
  assign out_is_count = out_is_count_r;
  assign out_coef_value = out_value_r;
  assign out_coef_count = out_count_r;

  always_comb begin
    state_nxt = state_r;
    ret_nxt = ret_r;
    len_nxt = len_r;
    rp_nxt = rp_r;
    byte_nxt = byte_r;
    fill_nxt = fill_r;
    run_nxt = run_r;
    kr_nxt = kr_r;
    ones_nxt = ones_r;
    wp_nxt = wp_r;
    val_nxt = val_r;
    sum_nxt = sum_r;
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    sign_nxt = sign_r;
    rice_gr_nxt = rice_gr_r;
    go_dec_nxt = go_dec_r;
    oob_nxt = oob_r;
    cidx_nxt = cidx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_is_count_nxt = out_is_count_r;
    out_value_nxt = out_value_r;
    out_count_nxt = out_count_r;
    c_we = 1'b0;
    c_waddr = wp_r[CW-1:0];
    c_wdata = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_mode) begin
            oob_nxt = ({1'b0, in_coef_index} >= TOTAL);
            state_nxt = S_RD_WAIT;
          end else begin
            if (len_r < MAX_LEN) len_nxt = len_r + LW'(1);
            if (in_last_byte) begin
              go_dec_nxt = 1'b1;
              cidx_nxt = '0;
              state_nxt = S_CLR;
            end
          end
        end
      end
      S_RD_WAIT: begin
        out_valid_nxt = 1'b1;
        out_is_count_nxt = 1'b0;
        out_value_nxt = oob_r ? 16'd0 : c_rdata;
        out_count_nxt = 13'd0;
        state_nxt = S_IDLE;
      end
      S_CLR: begin
        c_we = 1'b1;
        c_waddr = cidx_r;
        cidx_nxt = cidx_r + CW'(1);
        if (cidx_r == LAST_ADDR) begin
          if (go_dec_r) begin
            run_nxt = rlgr3_pkg::PARAM_INIT;
            kr_nxt = rlgr3_pkg::PARAM_INIT;
            rp_nxt = '0;
            fill_nxt = 4'd0;
            byte_nxt = 8'd0;
            wp_nxt = 13'd0;
            state_nxt = S_TOP;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_FETCH: begin
        byte_nxt = s_rdata;
        fill_nxt = 4'd8;
        state_nxt = ret_r;
      end
      S_TOP: begin
        if (stream_done) begin
          state_nxt = S_FINISH;
        end else if (run_r[6:3] != 4'd0) begin
          state_nxt = S_RUN_BIT;
        end else begin
          rice_gr_nxt = 1'b1;
          ones_nxt = 7'd0;
          val_nxt = 16'd0;
          state_nxt = S_RICE_ONES;
        end
      end
      S_RUN_BIT: begin
        if (stream_done) begin
          state_nxt = S_FINISH;
        end else if (need_fetch) begin
          ret_nxt = state_r;
          rp_nxt = rp_r + LW'(1);
          state_nxt = S_FETCH;
        end else begin
          fill_nxt = fill_r - 4'd1;
          if (cur_bit) begin
            val_nxt = 16'd0;
            cnt_nxt = {1'b0, run_r[6:3]};
            state_nxt = S_RUN_K;
          end else begin
            run_nxt = rlgr3_pkg::sat_add(run_r, rlgr3_pkg::RUN_UP);
            if (wp_run >= TOTAL) begin
              wp_nxt = TOTAL;
              state_nxt = S_FINISH;
            end else begin
              wp_nxt = wp_run;
            end
          end
        end
      end
      S_RUN_K: begin
        if (cnt_r == 5'd0) begin
          wp_nxt = wp_r + {3'b000, val_r[9:0]};
          state_nxt = S_RUN_SIGN;
        end else if (need_fetch) begin
          ret_nxt = state_r;
          rp_nxt = rp_r + LW'(1);
          state_nxt = S_FETCH;
        end else begin
          if (fill_r != 4'd0) fill_nxt = fill_r - 4'd1;
          val_nxt = {val_r[14:0], cur_bit};
          cnt_nxt = cnt_r - 5'd1;
        end
      end
      S_RUN_SIGN: begin
        if (need_fetch) begin
          ret_nxt = state_r;
          rp_nxt = rp_r + LW'(1);
          state_nxt = S_FETCH;
        end else begin
          if (fill_r != 4'd0) fill_nxt = fill_r - 4'd1;
          sign_nxt = cur_bit;
          rice_gr_nxt = 1'b0;
          ones_nxt = 7'd0;
          val_nxt = 16'd0;
          state_nxt = S_RICE_ONES;
        end
      end
      S_RICE_ONES: begin
        if (stream_done) begin
          cnt_nxt = {1'b0, kr_r[6:3]};
          state_nxt = S_RICE_LOW;
        end else if (need_fetch) begin
          ret_nxt = state_r;
          rp_nxt = rp_r + LW'(1);
          state_nxt = S_FETCH;
        end else begin
          fill_nxt = fill_r - 4'd1;
          if (cur_bit) begin
            if (ones_r != 7'h7f) ones_nxt = ones_r + 7'd1;
            val_nxt = val_r + 16'd1;
          end else begin
            cnt_nxt = {1'b0, kr_r[6:3]};
            state_nxt = S_RICE_LOW;
          end
        end
      end
      S_RICE_LOW: begin
        if (cnt_r == 5'd0) begin
          if (ones_r == 7'd0) begin
            kr_nxt = rlgr3_pkg::sat_sub(kr_r, rlgr3_pkg::RICE_DOWN);
          end else if (ones_r != 7'd1) begin
            kr_nxt = rlgr3_pkg::sat_add(kr_r, ones_r);
          end
          state_nxt = rice_gr_r ? S_GR_SETUP : S_RUN_PUT;
        end else if (need_fetch) begin
          ret_nxt = state_r;
          rp_nxt = rp_r + LW'(1);
          state_nxt = S_FETCH;
        end else begin
          if (fill_r != 4'd0) fill_nxt = fill_r - 4'd1;
          val_nxt = {val_r[14:0], cur_bit};
          cnt_nxt = cnt_r - 5'd1;
        end
      end
      S_RUN_PUT: begin
        c_we = (wp_r < TOTAL);
        c_wdata = sign_r ? 16'(17'd0 - mag) : mag[15:0];
        run_nxt = rlgr3_pkg::sat_sub(run_r, rlgr3_pkg::RUN_STEP);
        if (wp_one >= TOTAL) begin
          wp_nxt = TOTAL;
          state_nxt = S_FINISH;
        end else begin
          wp_nxt = wp_one;
          state_nxt = S_TOP;
        end
      end
      S_GR_SETUP: begin
        sum_nxt = val_r;
        cnt_nxt = rlgr3_pkg::bit_length(val_r);
        val_nxt = 16'd0;
        state_nxt = S_GR_V1;
      end
      S_GR_V1: begin
        if (cnt_r == 5'd0) begin
          state_nxt = S_GR_PUT1;
        end else if (need_fetch) begin
          ret_nxt = state_r;
          rp_nxt = rp_r + LW'(1);
          state_nxt = S_FETCH;
        end else begin
          if (fill_r != 4'd0) fill_nxt = fill_r - 4'd1;
          val_nxt = {val_r[14:0], cur_bit};
          cnt_nxt = cnt_r - 5'd1;
        end
      end
      S_GR_PUT1: begin
        c_we = (wp_r < TOTAL);
        c_wdata = rlgr3_pkg::from_mag_sign($signed({2'b00, val_r}));
        if ((val_r != 16'd0) && (d2 != 18'sd0)) begin
          run_nxt = rlgr3_pkg::sat_sub(run_r, rlgr3_pkg::RUN_STEP);
        end else if ((val_r == 16'd0) && (d2 == 18'sd0)) begin
          run_nxt = rlgr3_pkg::sat_add(run_r, rlgr3_pkg::RUN_STEP);
        end
        state_nxt = S_GR_PUT2;
      end
      S_GR_PUT2: begin
        c_we = (wp_one < TOTAL);
        c_waddr = wp_one[CW-1:0];
        c_wdata = rlgr3_pkg::from_mag_sign(d2);
        if (wp_two >= TOTAL) begin
          wp_nxt = TOTAL;
          state_nxt = S_FINISH;
        end else begin
          wp_nxt = wp_two;
          state_nxt = S_TOP;
        end
      end
      S_FINISH: begin
        cidx_nxt = DS_ADDR;
        state_nxt = DIFF_ON ? S_DIFF_RD : S_DONE;
      end
      S_DIFF_RD: begin
        state_nxt = S_DIFF_WR;
      end
      S_DIFF_WR: begin
        acc_nxt = diff_sum;
        c_we = 1'b1;
        c_waddr = cidx_r;
        c_wdata = diff_sum;
        cidx_nxt = cidx_r + CW'(1);
        state_nxt = (cidx_r == LAST_ADDR) ? S_DONE : S_DIFF_RD;
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        out_is_count_nxt = 1'b1;
        out_value_nxt = 16'd0;
        out_count_nxt = wp_r;
        len_nxt = '0;
        go_dec_nxt = 1'b0;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      ret_r <= S_IDLE;
      len_r <= '0;
      rp_r <= '0;
      fill_r <= 4'd0;
      run_r <= rlgr3_pkg::PARAM_INIT;
      kr_r <= rlgr3_pkg::PARAM_INIT;
      wp_r <= 13'd0;
      go_dec_r <= 1'b0;
      cidx_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r <= ret_nxt;
      len_r <= len_nxt;
      rp_r <= rp_nxt;
      fill_r <= fill_nxt;
      run_r <= run_nxt;
      kr_r <= kr_nxt;
      wp_r <= wp_nxt;
      go_dec_r <= go_dec_nxt;
      cidx_r <= cidx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    ones_r <= ones_nxt;
    val_r <= val_nxt;
    sum_r <= sum_nxt;
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
    sign_r <= sign_nxt;
    rice_gr_r <= rice_gr_nxt;
    oob_r <= oob_nxt;
    out_is_count_r <= out_is_count_nxt;
    out_value_r <= out_value_nxt;
    out_count_r <= out_count_nxt;
  end

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (state_r == S_IDLE))
    else $error("request taken while the sequencer is busy");
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= 4'd8)
    else $error("bit reservoir fill out of range");
  a_param_range: assert property (@(posedge clk) disable iff (!rst_n)
    (run_r <= rlgr3_pkg::PARAM_MAX) && (kr_r <= rlgr3_pkg::PARAM_MAX))
    else $error("adaptive parameter above its ceiling");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> (wp_r <= TOTAL))
    else $error("coefficient count above store size");
  a_fetch_return: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FETCH) |=> (fill_r == 4'd8))
    else $error("byte fetch did not refill the reservoir");
`endif

endmodule
`default_nettype wire

/* src/rlgr3_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module rlgr3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
